// File: rtl/pslp_pkg.sv
// ----------------------------------------------------------------------------
// pslp_pkg
// Types and constants shared by the speed-loop PID drive unit.
// ----------------------------------------------------------------------------
package pslp_pkg;

   // Input modes
   localparam logic [1:0] MODE_RUN  = 2'd0;
   localparam logic [1:0] MODE_STOP = 2'd1;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_GAIN_P   = 2'd0;
   localparam logic [1:0] CSR_GAIN_I   = 2'd1;
   localparam logic [1:0] CSR_GAIN_D   = 2'd2;
   localparam logic [1:0] CSR_PWM_PER  = 2'd3;

   // Register reset values
   localparam logic signed [23:0] GAIN_P_RESET  = 24'sd65536;
   localparam logic [15:0]        PWM_PER_RESET = 16'd999;

   // Controller output limit: 100 percent in Q.24
   localparam longint Q24_HUNDRED = 64'sd1677721600;

   // Divide by 100 as multiply by ceil(2^30/100), exact for inputs below 2^23
   localparam logic signed [24:0] DIV_RECIP = 25'sd10737419;
   localparam int                 DIV_SHIFT = 30;

   // Rounding offset for Q.24 to Q.8
   localparam logic [31:0] ROUND_HALF = 32'd32768;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [23:0] setpoint_speed;
      logic signed [23:0] measured_speed;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_level;
      logic [15:0]        pwm_compare;
      logic               dir_a_level;
      logic               dir_b_level;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_CLAMP,
      ST_ROUND,
      ST_MUL_PWM,
      ST_MUL_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_P,
      OP_I,
      OP_D,
      OP_PWM,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic   load_err;
      logic   stop_clr;
      logic   mul_en;
      op_type op_sel;
      logic   acc_clr;
      logic   acc_en;
      logic   last_upd;
      logic   clamp_en;
      logic   round_en;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: rtl/pid_speed_loop_pwm_drive_unit.sv
// ----------------------------------------------------------------------------
// pid_speed_loop_pwm_drive_unit
// Speed-loop PID with clamped integral, output clamp, PWM compare and
// direction pins, run as a sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Run tick: five passes through the single multiplier (P, I, D, PWM, divide)
// plus accumulate, clamp, round and output load; the next input is taken only
// after the output load. Stop tick: loads a zero result. A tick in any other
// mode is taken and gives no result. A stalled result holds the next input.
// Synchronous reset clears integral, previous error and the output valid, and
// restores gains and PWM period to their defaults.
module pid_speed_loop_pwm_drive_unit #(
   parameter int TICK_RATE = 1000
) (
   input  logic              clock,
   input  logic              reset,
   // Input items
   input  logic              req_valid,
   output logic              req_stall,
   input  pslp_pkg::req_type req_data,
   // Result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pslp_pkg::rsp_type rsp_data,
   // Register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import pslp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Registers are to be written only between ticks; the block does not enforce it
   assign csr_ready = 1'b1;

   pslp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pslp_datapath #(
      .TICK_RATE (TICK_RATE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/pslp_ctrl.sv
// ----------------------------------------------------------------------------
// pslp_ctrl
// Sequencer for one control tick: steps the shared multiplier through the
// P, I, D, PWM and divide products and hands the result to the output stage.
// ----------------------------------------------------------------------------
module pslp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_stall,
   input  pslp_pkg::status_type status,
   output pslp_pkg::cmd_type    cmd
);
   import pslp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Take new items only between ticks
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.op_sel   = OP_P;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_RUN) begin
                  cmd.load_err = 1'b1;
                  state_in     = ST_MUL_P;
               end else if (req_mode == MODE_STOP) begin
                  cmd.stop_clr = 1'b1;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.op_sel  = OP_P;
            cmd.acc_clr = 1'b1;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en = 1'b1;
            cmd.op_sel = OP_I;
            cmd.acc_en = 1'b1;
            state_in   = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en   = 1'b1;
            cmd.op_sel   = OP_D;
            cmd.acc_en   = 1'b1;
            cmd.last_upd = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_MUL_PWM;
         end
         ST_MUL_PWM: begin
            cmd.mul_en = 1'b1;
            cmd.op_sel = OP_PWM;
            state_in   = ST_MUL_DIV;
         end
         ST_MUL_DIV: begin
            cmd.mul_en = 1'b1;
            cmd.op_sel = OP_DIV;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register can take the result
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/pslp_datapath.sv
// ----------------------------------------------------------------------------
// pslp_datapath
// Error and integral state, gain registers, one shared multiplier with its
// accumulator, clamp and rounding, PWM scaling and the output register.
// ----------------------------------------------------------------------------
module pslp_datapath #(
   parameter int TICK_RATE = 1000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pslp_pkg::req_type    req_data,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_wdata,
   input  pslp_pkg::cmd_type    cmd,
   output pslp_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pslp_pkg::rsp_type    rsp_data
);
   import pslp_pkg::*;

   // Integral limit is 100 speed-seconds in Q.8 ticks
   localparam longint SUM_LIM_L = longint'(100) * longint'(TICK_RATE) * longint'(256);
   localparam int     SUM_W     = $clog2(SUM_LIM_L + 1) + 1;
   localparam int     B_W       = (SUM_W > 26) ? SUM_W : 26;
   localparam int     PROD_W    = 25 + B_W;
   localparam int     ACC_W     = PROD_W + 2;
   localparam logic signed [SUM_W:0]   SUM_LIM = (SUM_W + 1)'(SUM_LIM_L);
   localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(Q24_HUNDRED);

   // Configuration registers
   logic signed [23:0] gain_p_ff;
   logic signed [23:0] gain_i_ff;
   logic signed [23:0] gain_d_ff;
   logic [15:0]        pwm_per_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= GAIN_P_RESET;
         gain_i_ff  <= '0;
         gain_d_ff  <= '0;
         pwm_per_ff <= PWM_PER_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:  gain_p_ff  <= csr_wdata;
            CSR_GAIN_I:  gain_i_ff  <= csr_wdata;
            CSR_GAIN_D:  gain_d_ff  <= csr_wdata;
            CSR_PWM_PER: pwm_per_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Error, clamped integral and previous error
   logic signed [24:0]      err_ff;
   logic signed [24:0]      last_ff;
   logic signed [SUM_W-1:0] esum_ff;
   logic signed [24:0]      err_in;
   logic signed [SUM_W:0]   esum_raw;
   logic signed [SUM_W-1:0] esum_in;

   assign err_in   = 25'(req_data.setpoint_speed) - 25'(req_data.measured_speed);
   assign esum_raw = (SUM_W + 1)'(esum_ff) + (SUM_W + 1)'(err_in);

   always_comb begin
      if (esum_raw > SUM_LIM) begin
         esum_in = SUM_W'(SUM_LIM);
      end else if (esum_raw < -SUM_LIM) begin
         esum_in = SUM_W'(-SUM_LIM);
      end else begin
         esum_in = SUM_W'(esum_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esum_ff <= '0;
         last_ff <= '0;
      end else begin
         if (cmd.load_err) begin
            esum_ff <= esum_in;
         end
         if (cmd.last_upd) begin
            last_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         err_ff <= err_in;
      end
   end

   // Shared multiplier operand select
   logic signed [25:0]       err_diff;
   logic signed [24:0]       mul_a;
   logic signed [B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [15:0]              mag_ff;
   logic signed [15:0]       drive_ff;

   assign err_diff = 26'(err_ff) - 26'(last_ff);

   always_comb begin
      case (cmd.op_sel)
         OP_P: begin
            mul_a = 25'(gain_p_ff);
            mul_b = B_W'(err_ff);
         end
         OP_I: begin
            mul_a = 25'(gain_i_ff);
            mul_b = B_W'(esum_ff);
         end
         OP_D: begin
            mul_a = 25'(gain_d_ff);
            mul_b = B_W'(err_diff);
         end
         OP_PWM: begin
            mul_a = signed'(25'(mag_ff));
            mul_b = signed'(B_W'(pwm_per_ff));
         end
         OP_DIV: begin
            mul_a = DIV_RECIP;
            mul_b = signed'(B_W'(prod_ff[30:8]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Register each product; clear it for a stop result
   always_ff @(posedge clock) begin
      if (cmd.stop_clr) begin
         prod_ff <= '0;
      end else if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Accumulate P, I and D terms
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Clamp to +/-100 percent
   logic signed [31:0] accc_ff;

   always_ff @(posedge clock) begin
      if (cmd.clamp_en) begin
         if (acc_ff > ACC_LIM) begin
            accc_ff <= 32'(ACC_LIM);
         end else if (acc_ff < -ACC_LIM) begin
            accc_ff <= 32'(-ACC_LIM);
         end else begin
            accc_ff <= 32'(acc_ff);
         end
      end
   end

   // Round to Q7.8, ties away from zero
   logic [31:0] abs_val;
   logic [31:0] rnd_val;
   logic [15:0] dmag;

   assign abs_val = accc_ff[31] ? 32'(-accc_ff) : 32'(accc_ff);
   assign rnd_val = abs_val + ROUND_HALF;
   assign dmag    = rnd_val[31:16];

   always_ff @(posedge clock) begin
      if (cmd.stop_clr) begin
         drive_ff <= '0;
         mag_ff   <= '0;
      end else if (cmd.round_en) begin
         mag_ff   <= dmag;
         drive_ff <= accc_ff[31] ? -signed'(dmag) : signed'(dmag);
      end
   end

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.drive_level <= drive_ff;
         rsp_data_ff.pwm_compare <= prod_ff[DIV_SHIFT +: 16];
         rsp_data_ff.dir_a_level <= (drive_ff > 16'sd0);
         rsp_data_ff.dir_b_level <= drive_ff[15];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
